@@ sv/single_wire_sensor_frame_decoder_top_assert.svh @@
// Assertion macros used by the sensor frame decoder core.
`ifndef SINGLE_WIRE_SENSOR_FRAME_DECODER_TOP_ASSERT_SVH
`define SINGLE_WIRE_SENSOR_FRAME_DECODER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define SWSD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("swsd assertion failed");
// Next-cycle implication, checked out of reset.
`define SWSD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("swsd assertion failed");
`else
`define SWSD_ASSERT_NOW(lbl, ante, cons)
`define SWSD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ sv/swsd_pkg.sv @@
// Package with the types and constants of the sensor frame decoder.
package swsd_pkg;

	localparam int DATA_BITS = 40;
	localparam int FRAME_W = 40;
	localparam int PHASE_W = $clog2(3 + 2 * DATA_BITS);

	localparam logic [PHASE_W-1:0] PH_IDLE = PHASE_W'(0);
	localparam logic [PHASE_W-1:0] PH_RESP_LOW = PHASE_W'(1);
	localparam logic [PHASE_W-1:0] PH_RESP_HIGH = PHASE_W'(2);
	localparam logic [PHASE_W-1:0] PH_BITS = PHASE_W'(3);
	localparam logic [PHASE_W-1:0] PH_LAST = PHASE_W'(3 + 2 * DATA_BITS - 1);

	localparam logic [15:0] MAX_CYCLES_RESET = 16'd1000;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_RESP  = 2'd1,
		ST_BIT_ERR  = 2'd2,
		ST_CSUM_ERR = 2'd3
	} status_t;

	typedef struct packed {
		status_t            status;
		logic [15:0]        humidity;
		logic signed [15:0] temperature;
	} result_t;

endpackage

@@ sv/single_wire_sensor_frame_decoder_top.sv @@
// Single-wire sensor frame decoder: top level with input and result registers.
//
// Usage: after the host has driven its start pulse, send one transfer on the
// slave side with s_tuser = 1 to arm the receiver, then one transfer per
// sampling tick with s_tuser = 0 and the sampled line level in s_tdata[0].
// A begin transfer during a frame drops that frame and re-arms the receiver.
// When a frame completes or fails, one result transfer appears on the master
// side carrying status, humidity and temperature; ticks that end nothing give
// no result, and ticks while idle are ignored.
// A result is built from the item in the input register and held in the
// result register. Throughput: one transfer per cycle while no result is
// stalled; each tick is decoded combinationally between the two registers.
// When the receiver stalls with a result pending, the input register holds
// its item and s_tready drops until the result is taken.
// Reset clears the decoder to idle and sets max_cycles to 1000; cfg_we writes
// max_cycles and should only be used while no frame is in progress.
module single_wire_sensor_frame_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,   // max_cycles
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,     // [0] pin_level, [7:1] zero
	input  logic [0:0]  s_tuser,     // [0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata      // [1:0] status, [17:2] humidity,
	                                 // [33:18] temperature, [39:34] zero
);

	logic              valid_s1, op_s1, pin_s1;
	logic [15:0]       max_cycles_q;
	logic              out_valid_q;
	swsd_pkg::result_t out_q;
	swsd_pkg::result_t core_res;
	logic              step, emit;

	assign step = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_cycles_q <= swsd_pkg::MAX_CYCLES_RESET;
		end else if (cfg_we) begin
			max_cycles_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1 <= s_tuser[0];
			pin_s1 <= s_tdata[0];
		end
	end

	swsd_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.max_cycles (max_cycles_q),
		.step       (step),
		.op         (op_s1),
		.pin        (pin_s1),
		.emit       (emit),
		.res        (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			out_q <= core_res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {6'b0, out_q.temperature, out_q.humidity, out_q.status};

endmodule

@@ sv/swsd_frame_check.sv @@
// Checksum test and field extraction for one received 40-bit frame.
module swsd_frame_check (
	input  logic [swsd_pkg::FRAME_W-1:0] frame,
	output swsd_pkg::result_t            res
);

	logic [7:0]  b0, b1, b2, b3, b4;
	logic [7:0]  sum;
	logic [14:0] mag;

	always_comb begin
		b0 = frame[39:32];
		b1 = frame[31:24];
		b2 = frame[23:16];
		b3 = frame[15:8];
		b4 = frame[7:0];
		sum = b0 + b1 + b2 + b3;
		mag = {b2[6:0], b3};
		if (sum != b4) begin
			res.status = swsd_pkg::ST_CSUM_ERR;
			res.humidity = '0;
			res.temperature = '0;
		end else begin
			res.status = swsd_pkg::ST_OK;
			res.humidity = {b0, b1};
			// Sign-magnitude to two's complement.
			res.temperature = b2[7] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		end
	end

endmodule

@@ sv/swsd_core.sv @@
// Pulse measurement state machine: phase, pulse width counters and bit shifting.
`include "single_wire_sensor_frame_decoder_top_assert.svh"
module swsd_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [15:0]         max_cycles,
	input  logic                step,
	input  logic                op,
	input  logic                pin,
	output logic                emit,
	output swsd_pkg::result_t   res
);

	logic [swsd_pkg::PHASE_W-1:0] phase_q, phase_n, bit_idx, phase_inc;
	logic [15:0]                  pulse_count_q, pulse_count_n;
	logic [15:0]                  low_width_q, low_width_n;
	logic [swsd_pkg::FRAME_W-1:0] frame_q, frame_n;
	swsd_pkg::result_t            check_res;
	logic                         level, in_resp;

	swsd_frame_check u_check (
		.frame (frame_n),
		.res   (check_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= swsd_pkg::PH_IDLE;
			pulse_count_q <= '0;
			low_width_q <= '0;
			frame_q <= '0;
		end else begin
			phase_q <= phase_n;
			pulse_count_q <= pulse_count_n;
			low_width_q <= low_width_n;
			frame_q <= frame_n;
		end
	end

	always_comb begin
		phase_n = phase_q;
		pulse_count_n = pulse_count_q;
		low_width_n = low_width_q;
		frame_n = frame_q;
		emit = 1'b0;
		res.status = swsd_pkg::ST_OK;
		res.humidity = '0;
		res.temperature = '0;
		bit_idx = phase_q - swsd_pkg::PH_BITS;
		phase_inc = phase_q + swsd_pkg::PHASE_W'(1);
		in_resp = phase_q < swsd_pkg::PH_BITS;
		if (phase_q == swsd_pkg::PH_RESP_LOW) begin
			level = 1'b0;
		end else if (phase_q == swsd_pkg::PH_RESP_HIGH) begin
			level = 1'b1;
		end else begin
			level = bit_idx[0];
		end

		if (step) begin
			if (op) begin
				phase_n = swsd_pkg::PH_RESP_LOW;
				pulse_count_n = '0;
				low_width_n = '0;
				frame_n = '0;
			end else if (phase_q != swsd_pkg::PH_IDLE) begin
				if (pin == level) begin
					if (pulse_count_q >= max_cycles) begin
						emit = 1'b1;
						res.status = in_resp ? swsd_pkg::ST_NO_RESP : swsd_pkg::ST_BIT_ERR;
						phase_n = swsd_pkg::PH_IDLE;
					end else begin
						pulse_count_n = pulse_count_q + 16'd1;
					end
				end else if (pulse_count_q == '0) begin
					emit = 1'b1;
					res.status = in_resp ? swsd_pkg::ST_NO_RESP : swsd_pkg::ST_BIT_ERR;
					phase_n = swsd_pkg::PH_IDLE;
				end else begin
					if (!in_resp && bit_idx[0]) begin
						frame_n = {frame_q[swsd_pkg::FRAME_W-2:0], pulse_count_q > low_width_q};
					end else if (!in_resp) begin
						low_width_n = pulse_count_q;
					end
					if (!in_resp && phase_q == swsd_pkg::PH_LAST) begin
						emit = 1'b1;
						res = check_res;
						phase_n = swsd_pkg::PH_IDLE;
					end else if (max_cycles == '0) begin
						// The edge sample already starts the next pulse and times it out.
						emit = 1'b1;
						res.status = (phase_inc < swsd_pkg::PH_BITS) ?
							swsd_pkg::ST_NO_RESP : swsd_pkg::ST_BIT_ERR;
						phase_n = swsd_pkg::PH_IDLE;
					end else begin
						phase_n = phase_inc;
						pulse_count_n = 16'd1;
					end
				end
			end
		end
	end

	`SWSD_ASSERT_NOW(a_emit_needs_step, emit, step && !op)
	`SWSD_ASSERT_NEXT(a_idle_after_emit, emit, phase_q == swsd_pkg::PH_IDLE)
	`SWSD_ASSERT_NOW(a_phase_range, 1'b1, phase_q <= swsd_pkg::PH_LAST)
	`SWSD_ASSERT_NEXT(a_begin_arms, step && op,
		phase_q == swsd_pkg::PH_RESP_LOW && pulse_count_q == '0 && frame_q == '0)

endmodule
